### src/tfsa_pkg.sv
// shared types and constants of the triangle fan/strip assembler
package tfsa_pkg;

   // width of a coordinate field on the channels
   localparam int FIELD_WIDTH = 32;
   // default coordinate width kept inside the block
   localparam int COORD_WIDTH_DEFAULT = 32;
   // depth of the queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;
   // most vertices one item can emit
   localparam int MAX_VERTS = 3;

   typedef enum logic {
      CMD_BEGIN  = 1'b0,
      CMD_VERTEX = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_LIST  = 2'd0,
      KIND_STRIP = 2'd1,
      KIND_FAN   = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] x;
      logic [FIELD_WIDTH-1:0] y;
   } vertex_type;

   // one queued job: vertex count (1 or 3) and the vertices in emit order
   typedef struct packed {
      logic [1:0]                 count;
      vertex_type [MAX_VERTS-1:0] vtx;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### src/tfsa_if.sv
// channel interfaces of the triangle fan/strip assembler

interface tfsa_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [1:0]                          prim_kind;
   logic signed [tfsa_pkg::FIELD_WIDTH-1:0] x_coord;
   logic signed [tfsa_pkg::FIELD_WIDTH-1:0] y_coord;

   modport source (output valid, command, prim_kind, x_coord, y_coord, input ready);
   modport sink   (input valid, command, prim_kind, x_coord, y_coord, output ready);
endinterface

interface tfsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tfsa_pkg::FIELD_WIDTH-1:0] out_x;
   logic signed [tfsa_pkg::FIELD_WIDTH-1:0] out_y;
   logic                                run_last;

   modport source (output valid, out_x, out_y, run_last, input ready);
   modport sink   (input valid, out_x, out_y, run_last, output ready);
endinterface

### src/triangle_fan_strip_assembler.sv
// top level of the triangle fan/strip primitive assembler
//
//   channel    dir   payload                               role
//   req_chan   in    command, prim_kind, x_coord, y_coord  begin / vertex items
//   rsp_chan   out   out_x, out_y, run_last                triangle vertices
//
// The output delivers one vertex per cycle while rsp_chan.ready is high; an item
// emits 0, 1 or 3 vertices, so a fan or strip vertex in steady state emits a
// whole triangle. Begin items and silent vertices emit nothing.
// Reset clears primitive state to kind other, count zero, coordinates zero.
// A stalled output fills the two-entry job queue, then drops req_chan.ready.
module triangle_fan_strip_assembler #(
   parameter int COORD_WIDTH = tfsa_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = tfsa_pkg::QUEUE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   tfsa_req_if.sink    req_chan,
   tfsa_rsp_if.source  rsp_chan
);

   tfsa_pkg::job_type      push_job, head_job;
   tfsa_pkg::q_status_type q_status;
   logic                   push, pop;

   tfsa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   tfsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   tfsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // no job written into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("job pushed into full queue");

   // no job taken from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   // queued jobs only ever hold one or three vertices
   assert property (@(posedge clock) disable iff (reset)
                    push |-> (push_job.count == 2'd1 || push_job.count == 2'd3))
      else $error("job with bad vertex count");

   // a begin item never produces a job
   assert property (@(posedge clock) disable iff (reset)
                    (req_chan.valid && req_chan.ready &&
                     req_chan.command == tfsa_pkg::CMD_BEGIN) |-> !push)
      else $error("begin item produced a job");

endmodule

### src/tfsa_front.sv
// front end: accepts items, tracks primitive state, builds emit jobs
module tfsa_front #(
   parameter int COORD_WIDTH = tfsa_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   tfsa_req_if.sink               req_chan,
   input  tfsa_pkg::q_status_type q_status,
   output logic                   push,
   output tfsa_pkg::job_type      job
);

   // coordinates are kept at the narrower of the parameter and the field
   localparam int StoreW = (COORD_WIDTH < tfsa_pkg::FIELD_WIDTH) ?
                           COORD_WIDTH : tfsa_pkg::FIELD_WIDTH;

   tfsa_pkg::kind_type kind_ff, kind_in;
   logic [1:0]         count_ff, count_in;
   logic [StoreW-1:0]  anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic [StoreW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [StoreW-1:0]  vx, vy;
   logic               accept;

   tfsa_pkg::vertex_type cur_v, anchor_v, prev_v;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign vx = req_chan.x_coord[StoreW-1:0];
   assign vy = req_chan.y_coord[StoreW-1:0];

   assign cur_v.x    = tfsa_pkg::FIELD_WIDTH'(vx);
   assign cur_v.y    = tfsa_pkg::FIELD_WIDTH'(vy);
   assign anchor_v.x = tfsa_pkg::FIELD_WIDTH'(anchor_x_ff);
   assign anchor_v.y = tfsa_pkg::FIELD_WIDTH'(anchor_y_ff);
   assign prev_v.x   = tfsa_pkg::FIELD_WIDTH'(prev_x_ff);
   assign prev_v.y   = tfsa_pkg::FIELD_WIDTH'(prev_y_ff);

   // classify the item and work out the next state and the job
   always_comb begin
      kind_in     = kind_ff;
      count_in    = count_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      job.count   = 2'd0;
      job.vtx[0]  = cur_v;
      job.vtx[1]  = cur_v;
      job.vtx[2]  = cur_v;
      if (req_chan.command == tfsa_pkg::CMD_BEGIN) begin
         kind_in  = tfsa_pkg::kind_type'(req_chan.prim_kind);
         count_in = 2'd0;
      end else begin
         case (kind_ff)
            tfsa_pkg::KIND_LIST: begin
               job.count = 2'd1;
            end
            tfsa_pkg::KIND_FAN: begin
               case (count_ff)
                  2'd0: begin
                     anchor_x_in = vx;
                     anchor_y_in = vy;
                  end
                  2'd1: begin
                     prev_x_in = vx;
                     prev_y_in = vy;
                  end
                  default: begin
                     job.count  = 2'd3;
                     job.vtx[0] = anchor_v;
                     job.vtx[1] = prev_v;
                     prev_x_in  = vx;
                     prev_y_in  = vy;
                  end
               endcase
            end
            tfsa_pkg::KIND_STRIP: begin
               case (count_ff)
                  2'd0: begin
                     job.count = 2'd1;
                  end
                  2'd1: begin
                     job.count   = 2'd1;
                     anchor_x_in = vx;
                     anchor_y_in = vy;
                  end
                  2'd2: begin
                     job.count = 2'd1;
                     prev_x_in = vx;
                     prev_y_in = vy;
                  end
                  default: begin
                     job.count   = 2'd3;
                     job.vtx[0]  = anchor_v;
                     job.vtx[1]  = prev_v;
                     anchor_x_in = prev_x_ff;
                     anchor_y_in = prev_y_ff;
                     prev_x_in   = vx;
                     prev_y_in   = vy;
                  end
               endcase
            end
            default: begin
               job.count = 2'd0;
            end
         endcase
         // vertex count saturates at three
         if (count_ff != 2'd3) begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   assign push = accept && (job.count != 2'd0);

   // primitive state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= tfsa_pkg::KIND_OTHER;
         count_ff    <= 2'd0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
      end else if (accept) begin
         kind_ff     <= kind_in;
         count_ff    <= count_in;
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
      end
   end

endmodule

### src/tfsa_queue.sv
// short job queue between the front end and the back end
module tfsa_queue #(
   parameter int DEPTH = tfsa_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tfsa_pkg::job_type      push_job,
   input  logic                   pop,
   output tfsa_pkg::job_type      head_job,
   output tfsa_pkg::q_status_type status
);

   localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FillW = $clog2(DEPTH + 1);

   tfsa_pkg::job_type entries_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]  fill_ff, fill_in;

   assign status.full  = (fill_ff == FillW'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = FillW'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = FillW'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/tfsa_back.sv
// back end: output register gets queued jobs one vertex per cycle unless stalled
module tfsa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tfsa_pkg::job_type      head_job,
   input  tfsa_pkg::q_status_type q_status,
   output logic                   pop,
   tfsa_rsp_if.source             rsp_chan
);

   tfsa_pkg::job_type          job_ff;
   logic [1:0]                 idx_ff, idx_in;
   logic                       busy_ff, busy_in;
   logic                       valid_ff;
   tfsa_pkg::vertex_type       out_v_ff;
   logic                       last_ff;
   logic                       advance, last_vtx;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign last_vtx = (idx_ff == 2'(job_ff.count - 2'd1));

   // take the next job when idle or when the current one hands out its last vertex
   assign pop = !q_status.empty && (!busy_ff || (advance && last_vtx));

   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (busy_ff && advance) begin
         idx_in = idx_ff + 2'd1;
         if (last_vtx) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end
   end

   // job sequencing control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (advance) begin
            valid_ff <= busy_ff;
         end
      end
   end

   // job and output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (advance && busy_ff) begin
         out_v_ff <= job_ff.vtx[idx_ff];
         last_ff  <= last_vtx;
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_x    = out_v_ff.x;
   assign rsp_chan.out_y    = out_v_ff.y;
   assign rsp_chan.run_last = last_ff;

endmodule
